/* design/rcvtx_pkg.sv */
package rcvtx_pkg;

  localparam int unsigned DefChannelWidth = 11;

  localparam logic [15:0] IntervalReset = 16'd500;
  localparam logic [3:0]  RepeatsReset  = 4'd5;
  localparam logic [3:0]  MaxCopies     = 4'd8;
  localparam logic [3:0]  NoCode        = 4'd15;

  localparam int unsigned FrameLen = 6;

  localparam logic [7:0] ByteStart  = 8'h02;
  localparam logic [7:0] ByteLength = 8'h06;
  localparam logic [7:0] ByteCmd    = 8'h31;
  localparam logic [7:0] ByteEnd    = 8'h03;

  // Configuration register indexes.
  localparam logic CfgInterval = 1'b0;
  localparam logic CfgRepeats  = 1'b1;

  // Input item kinds carried on tuser.
  localparam logic ReqTick   = 1'b0;
  localparam logic ReqSample = 1'b1;

  // Byte positions inside one frame.
  localparam logic [2:0] PosStart  = 3'd0;
  localparam logic [2:0] PosLength = 3'd1;
  localparam logic [2:0] PosCmd    = 3'd2;
  localparam logic [2:0] PosCode   = 3'd3;
  localparam logic [2:0] PosCrc    = 3'd4;
  localparam logic [2:0] PosEnd    = 3'd5;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;   // input request taken this cycle
    logic advance;  // output byte taken this cycle
  } rcvtx_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic start;    // accepted sample opens a burst
    logic last;     // current byte closes the burst
  } rcvtx_stat_t;

  // Band code from a channel value in microseconds.
  function automatic logic [2:0] quantize(input logic [15:0] v);
    logic [2:0] code;
    code = 3'd0;
    if (v >= 16'd1000) code = 3'd1;
    if (v >= 16'd1100) code = 3'd2;
    if (v >= 16'd1210) code = 3'd3;
    if (v >= 16'd1350) code = 3'd4;
    if (v >= 16'd1450) code = 3'd5;
    if (v >= 16'd1560) code = 3'd6;
    if (v >= 16'd1875) code = 3'd7;
    return code;
  endfunction

  // One byte of the command frame.
  function automatic logic [7:0] frame_byte(input logic [2:0] pos, input logic [3:0] code);
    logic [7:0] b;
    unique case (pos)
      PosStart:  b = ByteStart;
      PosLength: b = ByteLength;
      PosCmd:    b = ByteCmd;
      PosCode:   b = {4'd0, code};
      PosCrc:    b = ByteLength ^ ByteCmd ^ {4'd0, code};
      PosEnd:    b = ByteEnd;
      default:   b = ByteEnd;
    endcase
    return b;
  endfunction

endpackage

/* design/rcvtx_ctrl.sv */
module rcvtx_ctrl
  import rcvtx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        out_ready,
  input  rcvtx_stat_t stat,
  output logic        in_ready,
  output logic        out_valid,
  output rcvtx_cmd_t  cmd
);

  localparam logic StIdle = 1'b0;
  localparam logic StSend = 1'b1;

  logic state_r;
  logic state_nxt;

  assign in_ready    = (state_r == StIdle);
  assign out_valid   = (state_r == StSend);
  assign cmd.accept  = in_valid & in_ready;
  assign cmd.advance = out_valid & out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      StIdle: begin
        if (cmd.accept && stat.start) state_nxt = StSend;
      end
      StSend: begin
        if (cmd.advance && stat.last) state_nxt = StIdle;
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/rcvtx_dp.sv */
module rcvtx_dp
  import rcvtx_pkg::*;
#(
  parameter int unsigned CHANNEL_WIDTH = DefChannelWidth
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rcvtx_cmd_t               cmd,
  input  logic                     req_type,
  input  logic [CHANNEL_WIDTH-1:0] channel_value,
  input  logic                     cfg_we,
  input  logic                     cfg_idx,
  input  logic [15:0]              cfg_wdata,
  output rcvtx_stat_t              stat,
  output logic [7:0]               tx_byte
);

  logic [15:0] interval_r;
  logic [3:0]  repeats_r;
  logic [15:0] ms_r,        ms_nxt;
  logic [3:0]  sent_r,      sent_nxt;
  logic [2:0]  pos_r,       pos_nxt;
  logic [3:0]  copies_r,    copies_nxt;

  logic        due;
  logic [3:0]  new_code;
  logic [3:0]  copies;

  assign due      = (ms_r > interval_r);
  assign new_code = {1'b0, quantize(16'(channel_value))};
  assign copies   = (repeats_r > MaxCopies) ? MaxCopies : repeats_r;

  assign stat.start = (req_type == ReqSample) && due && (new_code != sent_r) &&
                      (copies != 4'd0);
  assign stat.last  = (pos_r == PosEnd) && (copies_r == 4'd1);

  assign tx_byte = frame_byte(pos_r, sent_r);

  always_comb begin
    ms_nxt     = ms_r;
    sent_nxt   = sent_r;
    pos_nxt    = pos_r;
    copies_nxt = copies_r;
    if (cmd.accept) begin
      if (req_type == ReqTick) begin
        if (ms_r != 16'hFFFF) ms_nxt = ms_r + 16'd1;
      end else if (due) begin
        ms_nxt     = 16'd0;
        sent_nxt   = new_code;
        pos_nxt    = PosStart;
        copies_nxt = copies;
      end
    end else if (cmd.advance) begin
      if (pos_r == PosEnd) begin
        pos_nxt    = PosStart;
        copies_nxt = copies_r - 4'd1;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= IntervalReset;
      repeats_r  <= RepeatsReset;
      ms_r       <= 16'd0;
      sent_r     <= NoCode;
      pos_r      <= PosStart;
      copies_r   <= 4'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CfgInterval: interval_r <= cfg_wdata;
          CfgRepeats:  repeats_r  <= cfg_wdata[3:0];
          default:     interval_r <= interval_r;
        endcase
      end
      ms_r     <= ms_nxt;
      sent_r   <= sent_nxt;
      pos_r    <= pos_nxt;
      copies_r <= copies_nxt;
    end
  end

endmodule

/* design/rc_channel_to_vtx_frequency_command.sv */
// A burst starts the cycle after the sample that opens it.
// Throughput: one request per cycle while idle; a burst then sends 6 * min(frame_repeats, 8)
// bytes, one per cycle while out_tready is high.
// No request is taken while a burst is being sent.
// Reset (rst_n low at a clock edge): interval 500 ms, five repeats, counter zero, no code sent.
module rc_channel_to_vtx_frequency_command
  import rcvtx_pkg::*;
#(
  parameter int unsigned CHANNEL_WIDTH = DefChannelWidth
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Request channel.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((CHANNEL_WIDTH + 7) / 8)*8-1:0] in_tdata,  // [CHANNEL_WIDTH-1:0] channel_value
  input  logic                                  in_tuser,  // [0] req_type
  // Command byte channel.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata, // [7:0] tx_byte
  output logic                                  out_tlast, // last_byte
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [15:0]                           cfg_data
);

  rcvtx_cmd_t  cmd;
  rcvtx_stat_t stat;

  // Configuration writes are always taken; they only change the registers
  // read when the next request arrives.
  assign cfg_ready = 1'b1;

  // The controller owns the handshakes: it is either waiting for a request
  // or walking through a burst.
  rcvtx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  // The datapath keeps the millisecond counter, the last sent band code,
  // the configuration and the byte position inside the burst. The output
  // byte comes from registered position and code only, so it holds steady
  // while the sink stalls.
  rcvtx_dp #(
    .CHANNEL_WIDTH (CHANNEL_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .req_type      (in_tuser),
    .channel_value (in_tdata[CHANNEL_WIDTH-1:0]),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_idx       (cfg_index),
    .cfg_wdata     (cfg_data),
    .stat          (stat),
    .tx_byte       (out_tdata)
  );

  assign out_tlast = stat.last;

  // Requests and bytes never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken during a burst");

  // The burst ends exactly after its last byte.
  a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("burst continues past its last byte");

  // Each burst opens with the start byte.
  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> out_tdata == ByteStart)
    else $error("burst does not open with the start byte");

  // The last byte of a burst is always the frame end byte.
  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == ByteEnd)
    else $error("burst closes inside a frame");

endmodule

/* test/rcvtx_checker.sv */
`timescale 1ns / 1ps

module rcvtx_checker
  import rcvtx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending,
  output int          bytes_checked,
  output int          bursts
);

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } cmd_byte_t;

  cmd_byte_t   cmd_bytes_q[$];
  logic [15:0] interval_ms;
  logic [3:0]  repeat_count;
  logic [15:0] ms_elapsed;
  logic [3:0]  band_sent;

  initial begin
    fails         = 0;
    pending       = 0;
    bytes_checked = 0;
    bursts        = 0;
  end

  function automatic logic [3:0] band_of(input logic [DefChannelWidth-1:0] us);
    if (us >= 1875) return 4'd7;
    if (us >= 1560) return 4'd6;
    if (us >= 1450) return 4'd5;
    if (us >= 1350) return 4'd4;
    if (us >= 1210) return 4'd3;
    if (us >= 1100) return 4'd2;
    if (us >= 1000) return 4'd1;
    return 4'd0;
  endfunction

  task automatic report(input string what);
    fails++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    logic [7:0] frame [0:FrameLen-1];
    logic [3:0] band;
    int         copies;
    cmd_byte_t  got;
    cmd_byte_t  want;
    if (!rst_n) begin
      interval_ms  = IntervalReset;
      repeat_count = RepeatsReset;
      ms_elapsed   = '0;
      band_sent    = NoCode;
      cmd_bytes_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgInterval) begin
          interval_ms = cfg_data;
        end else begin
          repeat_count = cfg_data[3:0];
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == ReqTick) begin
          if (ms_elapsed != 16'hFFFF) ms_elapsed = ms_elapsed + 16'd1;
        end else if (ms_elapsed > interval_ms) begin
          ms_elapsed = '0;
          band = band_of(in_tdata[DefChannelWidth-1:0]);
          if (band != band_sent) begin
            band_sent = band;
            frame[0] = ByteStart;
            frame[1] = ByteLength;
            frame[2] = ByteCmd;
            frame[3] = {4'd0, band};
            frame[4] = ByteLength ^ ByteCmd ^ {4'd0, band};
            frame[5] = ByteEnd;
            copies = (repeat_count > MaxCopies) ? int'(MaxCopies) : int'(repeat_count);
            for (int c = 0; c < copies; c++) begin
              for (int b = 0; b < FrameLen; b++) begin
                cmd_bytes_q.push_back('{frame[b], (c == copies - 1) && (b == FrameLen - 1)});
              end
            end
            if (copies > 0) bursts++;
          end
        end
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata, out_tlast};
        if (cmd_bytes_q.size() == 0) begin
          report($sformatf("byte %02h (last %0b) with nothing expected", out_tdata, out_tlast));
        end else begin
          want = cmd_bytes_q.pop_front();
          if (got.tx_byte !== want.tx_byte)
            report($sformatf("tx_byte %02h, expected %02h", got.tx_byte, want.tx_byte));
          if (got.last_byte !== want.last_byte)
            report($sformatf("last_byte %0b, expected %0b", got.last_byte, want.last_byte));
          bytes_checked++;
        end
      end
    end
    pending = cmd_bytes_q.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rcvtx_pkg::*;

  // Cycles without any handshake on any channel before the run is declared hung.
  // The longest legal quiet stretch is a drain pause plus a random sender gap or
  // receiver stall, so this is a wide margin.
  localparam int IdleLimit = 4000;

  // Band edges in microseconds, with the ends of the channel range around them.
  localparam int Bounds [0:8] = '{0, 1000, 1100, 1210, 1350, 1450, 1560, 1875, 2048};

  // Values that walk across every band edge, each one changing or keeping the band.
  localparam logic [10:0] Sweep [0:14] = '{
    11'd2047, 11'd1874, 11'd1875, 11'd999, 11'd1000, 11'd1099, 11'd1100, 11'd1209,
    11'd1210, 11'd1349, 11'd1350, 11'd1449, 11'd1450, 11'd1559, 11'd1560
  };

  // Sender idle and receiver stall percentages for the four random phases.
  localparam int SendIdle [0:3] = '{0, 64, 0, 26};
  localparam int RecvStall [0:3] = '{0, 0, 64, 26};

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [10:0] channel_value, [15:11] zero
  logic        in_tuser   = 1'b0; // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] tx_byte
  logic        out_tlast;         // last_byte
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = 1'b0;
  logic [15:0] cfg_data   = '0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;
  int requests      = 0;
  int samples       = 0;
  int fails;
  int pending;
  int bytes_checked;
  int bursts;

  rc_channel_to_vtx_frequency_command dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rcvtx_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fails         (fails),
    .pending       (pending),
    .bytes_checked (bytes_checked),
    .bursts        (bursts)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The byte receiver stalls at random with the percentage of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // The watchdog restarts whenever something moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("Watchdog: no handshake for %0d cycles, %0d bytes still expected.",
               IdleLimit, pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request and returns in the time step right after it is taken.
  // Valid stays high afterwards so that back-to-back requests need no gap.
  task automatic send_req(input logic kind, input logic [10:0] value);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'd0, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests++;
    if (kind == ReqSample) samples++;
  endtask

  // Ticks carry random channel bits, which the block must ignore.
  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++) send_req(ReqTick, 11'($urandom));
  endtask

  // Stops sending and waits until every expected byte has come out. A first
  // wait lets the checker book the last request before its count is read, and
  // the tail covers a sample still being judged when the last byte left.
  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Registers change only while the block is idle.
  task automatic write_reg(input logic index, input logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Channel values: fully random, hugging a band edge, or anywhere inside one band.
  function automatic logic [10:0] pick_value();
    int band;
    band = $urandom_range(7);
    case ($urandom_range(2))
      0: begin
        return 11'($urandom);
      end
      1: begin
        return 11'(Bounds[band + 1] - 2 + $urandom_range(3));
      end
      default: begin
        return 11'($urandom_range(Bounds[band + 1] - 1, Bounds[band]));
      end
    endcase
  endfunction

  initial begin : stimulus
    int interval;
    int roll;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a 500 ms interval and five copies. A sample right after
    // reset and one after twenty ticks are both too early. Those samples leave
    // the counter running, so with a zero interval the next sample passes and
    // sends five copies, since band zero differs from the none-sent code.
    send_req(ReqSample, 11'd1500);
    send_ticks(20);
    send_req(ReqSample, 11'd1500);
    write_reg(CfgInterval, 16'd0);
    send_req(ReqSample, 11'd0);

    // Zero interval and single copies: walk across every band edge, so that some
    // samples change the band and some repeat it. A sample with no tick before it
    // is still too early.
    write_reg(CfgRepeats, 16'd1);
    foreach (Sweep[i]) begin
      send_ticks(1);
      send_req(ReqSample, Sweep[i]);
    end
    send_req(ReqSample, 11'd0);

    // With zero copies the new band is recorded silently, so the same band
    // afterwards must stay quiet as well.
    write_reg(CfgRepeats, 16'd0);
    send_ticks(1);
    send_req(ReqSample, 11'd1000);
    send_ticks(1);
    send_req(ReqSample, 11'd1050);

    // Eight copies, then a count above eight that must saturate to eight.
    write_reg(CfgRepeats, 16'd8);
    send_ticks(1);
    send_req(ReqSample, 11'd0);
    write_reg(CfgRepeats, 16'd15);
    send_ticks(1);
    send_req(ReqSample, 11'd2047);

    // Random phases, one per idle mix. Most groups are enough ticks to open the
    // interval followed by a sample; some samples come too early, and a few
    // stray ticks or samples are mixed in.
    for (int phase = 0; phase < 4; phase++) begin
      interval = $urandom_range(3);
      write_reg(CfgInterval, 16'(interval));
      write_reg(CfgRepeats, 16'($urandom_range(8, 1)));
      send_idle_pct = SendIdle[phase];
      stall_pct     = RecvStall[phase];
      for (int g = 0; g < 14; g++) begin
        // Halfway through, let every byte drain and pick a new copy count,
        // now and then one outside the usual range.
        if (g == 7) begin
          write_reg(CfgRepeats, ($urandom_range(4) == 0) ? 16'($urandom_range(15))
                                                        : 16'($urandom_range(8, 1)));
        end
        roll = $urandom_range(99);
        if (roll < 75) begin
          send_ticks(interval + 1 + $urandom_range(2));
          send_req(ReqSample, pick_value());
        end else if (roll < 90) begin
          send_ticks($urandom_range(interval));
          send_req(ReqSample, pick_value());
        end else begin
          send_req(1'($urandom), pick_value());
        end
      end
    end

    drain();
    $display("Run covered %0d requests, %0d of them channel samples, over four idle mixes.",
             requests, samples);
    $display("It checked %0d command bytes in %0d bursts.", bytes_checked, bursts);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/rcvtx_pkg.sv
design/rcvtx_ctrl.sv
design/rcvtx_dp.sv
design/rc_channel_to_vtx_frequency_command.sv
test/rcvtx_checker.sv
test/tb.sv
